// ===== rtl/core/nhcd_pkg.sv =====
// ----------------------------------------------------------------------------
// nhcd_pkg
// Shared types and constants for the nibble handshake channel deframer.
// ----------------------------------------------------------------------------
package nhcd_pkg;

    localparam int SAMPLE_W  = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 18;
    localparam int LIMIT_W   = 15;
    localparam int SCALE_W   = 18;
    localparam int OFFSET_W  = 12;
    localparam int NIB_W     = 4;
    localparam int POS_W     = 2;
    localparam int TICKS_W   = 12;
    localparam int CH_W      = 4;
    localparam int PULSE_W   = 15;
    localparam int PROD_W    = TICKS_W + SCALE_W;
    localparam int FRAC_W    = 16;
    localparam int US_W      = PROD_W + 1 - FRAC_W;
    localparam int DIFF_W    = US_W + 2;

    localparam int MAX_CHANNELS_DEF = 11;

    localparam logic [LIMIT_W-1:0]  TIMEOUT_RST = LIMIT_W'(25000);
    localparam logic [SCALE_W-1:0]  SCALE_RST   = SCALE_W'(56560);
    localparam logic [OFFSET_W-1:0] OFFSET_RST  = OFFSET_W'(1520);

    localparam logic [PROD_W:0]     ROUND_HALF  = (PROD_W+1)'(32'h8000);
    localparam logic [POS_W-1:0]    NIB_LAST    = POS_W'(2);

    localparam logic signed [DIFF_W-1:0] PULSE_MIN = -DIFF_W'(4095);
    localparam logic signed [DIFF_W-1:0] PULSE_MAX = DIFF_W'(16383);

    localparam int BIT_READY_N = 6;
    localparam int BIT_SYNC    = 3;
    localparam int BIT_DATA_N  = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT = 2'd0,
        CFG_SCALE   = 2'd1,
        CFG_OFFSET  = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        PH_READY = 1'b0,
        PH_IDLE  = 1'b1
    } phase_t;

    typedef struct packed {
        logic en;
        logic keep;
    } scale_ctl_t;

endpackage

// ===== rtl/core/nhcd_scale.sv =====
// ----------------------------------------------------------------------------
// nhcd_scale
// Converts a tick count to microseconds with a Q16 scale, rounds half up,
// subtracts the offset and saturates; one multiply stage, one result stage.
// ----------------------------------------------------------------------------
module nhcd_scale
    import nhcd_pkg::*;
(
    input  logic                       clk,
    input  scale_ctl_t                 ctl,
    input  logic [TICKS_W-1:0]         ticks,
    input  logic [SCALE_W-1:0]         scale_q16,
    input  logic [OFFSET_W-1:0]        offset_us,
    output logic signed [PULSE_W-1:0]  pulse
);

    logic [PROD_W-1:0]          product_reg;
    logic                       keep_reg;
    logic signed [PULSE_W-1:0]  pulse_reg;
    logic [PROD_W:0]            rounded;
    logic [US_W-1:0]            us;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [PULSE_W-1:0]  pulse_next;

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            product_reg <= PROD_W'(ticks * scale_q16);
            keep_reg    <= ctl.keep;
            pulse_reg   <= pulse_next;
        end
    end

    always_comb
    begin
        rounded = {1'b0, product_reg} + ROUND_HALF;
        us      = rounded[PROD_W:FRAC_W];
        diff    = $signed({1'b0, us}) - $signed({{(DIFF_W-OFFSET_W){1'b0}}, offset_us});
        if (!keep_reg)
        begin
            pulse_next = '0;
        end
        else if (diff > PULSE_MAX)
        begin
            pulse_next = PULSE_MAX[PULSE_W-1:0];
        end
        else if (diff < PULSE_MIN)
        begin
            pulse_next = PULSE_MIN[PULSE_W-1:0];
        end
        else
        begin
            pulse_next = diff[PULSE_W-1:0];
        end
    end

    assign pulse = pulse_reg;

endmodule

// ===== rtl/core/nibble_handshake_channel_deframer.sv =====
// ----------------------------------------------------------------------------
// nibble_handshake_channel_deframer
// Decodes a polled nibble handshake into scaled channel pulse widths.
//
// Each transaction on the s_axis channel carries one sample of the status
// byte. Every sample produces exactly one transaction on the m_axis channel,
// carrying the request line, any completed channel with its raw tick count
// and its scaled pulse width, and the sync, timeout and overrun flags.
// The cfg channel writes the timeout limit, the scale and the offset; it is
// always ready and should only be used while no samples are in flight.
// One sample is accepted every cycle while the result is not stalled. The
// four stages are the input register, the handshake state update, the
// scale multiplier and the result register.
// Reset empties the pipeline, returns the handshake to waiting for ready,
// clears the channel position and loads the default register values.
// When the receiver stalls, the whole pipeline holds and s_axis_tready
// falls until the pending result is taken.
// ----------------------------------------------------------------------------
module nibble_handshake_channel_deframer
    import nhcd_pkg::*;
#(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // status_sample[7:0]
    input  logic [SAMPLE_W-1:0]   s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // request_data[0], channel_index[4:1], channel_ticks[16:5],
    // pulse_offset_us[31:17]
    output logic [31:0]           m_axis_tdata,
    // channel_valid[0], frame_sync[1], timed_out[2], channel_overrun[3]
    output logic [3:0]            m_axis_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DAT_W-1:0]  cfg_data
);

    logic                   adv;

    logic [LIMIT_W-1:0]     timeout_limit_reg;
    logic [SCALE_W-1:0]     scale_q16_reg;
    logic [OFFSET_W-1:0]    offset_us_reg;

    logic                   v0_reg, v1_reg, v2_reg, v3_reg;
    logic [SAMPLE_W-1:0]    sample_reg;

    phase_t                 phase_reg, phase_next;
    logic [LIMIT_W-1:0]     wait_count_reg, wait_count_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [TICKS_W-1:0]     partial_reg, partial_next;
    logic [CH_W-1:0]        next_ch_reg, next_ch_next;

    logic                   req_next, cvalid_next, sync_next, tout_next, ovr_next;
    logic [CH_W-1:0]        idx_next;
    logic [TICKS_W-1:0]     ticks_next;
    logic [NIB_W-1:0]       nib;
    logic [TICKS_W-1:0]     merged;
    logic [LIMIT_W:0]       wait_inc;
    logic                   satisfied;

    logic                   req1_reg, cvalid1_reg, sync1_reg, tout1_reg, ovr1_reg;
    logic [CH_W-1:0]        idx1_reg;
    logic [TICKS_W-1:0]     ticks1_reg;

    logic                   req2_reg, cvalid2_reg, sync2_reg, tout2_reg, ovr2_reg;
    logic [CH_W-1:0]        idx2_reg;
    logic [TICKS_W-1:0]     ticks2_reg;

    logic                   req3_reg, cvalid3_reg, sync3_reg, tout3_reg, ovr3_reg;
    logic [CH_W-1:0]        idx3_reg;
    logic [TICKS_W-1:0]     ticks3_reg;

    scale_ctl_t             scale_ctl;
    logic signed [PULSE_W-1:0] pulse;

    assign adv           = !v3_reg || m_axis_tready;
    assign s_axis_tready = adv;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_limit_reg <= TIMEOUT_RST;
            scale_q16_reg     <= SCALE_RST;
            offset_us_reg     <= OFFSET_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_TIMEOUT: timeout_limit_reg <= cfg_data[LIMIT_W-1:0];
                CFG_SCALE:   scale_q16_reg     <= cfg_data[SCALE_W-1:0];
                CFG_OFFSET:  offset_us_reg     <= cfg_data[OFFSET_W-1:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg         <= 1'b0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            v3_reg         <= 1'b0;
            phase_reg      <= PH_READY;
            wait_count_reg <= '0;
            pos_reg        <= '0;
            partial_reg    <= '0;
            next_ch_reg    <= '0;
        end
        else if (adv)
        begin
            v0_reg <= s_axis_tvalid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (v0_reg)
            begin
                phase_reg      <= phase_next;
                wait_count_reg <= wait_count_next;
                pos_reg        <= pos_next;
                partial_reg    <= partial_next;
                next_ch_reg    <= next_ch_next;
            end
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        wait_count_next = wait_count_reg;
        pos_next        = pos_reg;
        partial_next    = partial_reg;
        next_ch_next    = next_ch_reg;
        cvalid_next     = 1'b0;
        sync_next       = 1'b0;
        tout_next       = 1'b0;
        ovr_next        = 1'b0;
        idx_next        = '0;
        ticks_next      = '0;
        nib             = {~sample_reg[BIT_DATA_N], sample_reg[5:3]};
        merged          = partial_reg | (TICKS_W'(nib) << {pos_reg, 2'b00});
        wait_inc        = {1'b0, wait_count_reg} + (LIMIT_W+1)'(1);
        satisfied       = (phase_reg == PH_READY) ? !sample_reg[BIT_READY_N]
                                                  : sample_reg[BIT_READY_N];
        if (satisfied)
        begin
            wait_count_next = '0;
            unique case (phase_reg)
                PH_READY:
                begin
                    if (pos_reg == NIB_LAST)
                    begin
                        cvalid_next  = 1'b1;
                        ticks_next   = merged;
                        pos_next     = '0;
                        partial_next = '0;
                        if (next_ch_reg >= CH_W'(MAX_CHANNELS))
                        begin
                            idx_next     = CH_W'(MAX_CHANNELS - 1);
                            ovr_next     = 1'b1;
                            next_ch_next = CH_W'(MAX_CHANNELS);
                        end
                        else
                        begin
                            idx_next     = next_ch_reg;
                            next_ch_next = next_ch_reg + CH_W'(1);
                        end
                    end
                    else
                    begin
                        pos_next     = pos_reg + POS_W'(1);
                        partial_next = merged;
                    end
                    phase_next = PH_IDLE;
                end
                PH_IDLE:
                begin
                    if (sample_reg[BIT_SYNC])
                    begin
                        sync_next    = 1'b1;
                        next_ch_next = '0;
                        pos_next     = '0;
                        partial_next = '0;
                    end
                    phase_next = PH_READY;
                end
            endcase
        end
        else if (wait_inc >= {1'b0, timeout_limit_reg})
        begin
            tout_next       = 1'b1;
            wait_count_next = '0;
            pos_next        = '0;
            partial_next    = '0;
            phase_next      = PH_READY;
        end
        else
        begin
            wait_count_next = wait_inc[LIMIT_W-1:0];
        end
        req_next = (phase_next == PH_READY);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sample_reg  <= s_axis_tdata;

            req1_reg    <= req_next;
            cvalid1_reg <= cvalid_next;
            sync1_reg   <= sync_next;
            tout1_reg   <= tout_next;
            ovr1_reg    <= ovr_next;
            idx1_reg    <= idx_next;
            ticks1_reg  <= ticks_next;

            req2_reg    <= req1_reg;
            cvalid2_reg <= cvalid1_reg;
            sync2_reg   <= sync1_reg;
            tout2_reg   <= tout1_reg;
            ovr2_reg    <= ovr1_reg;
            idx2_reg    <= idx1_reg;
            ticks2_reg  <= ticks1_reg;

            req3_reg    <= req2_reg;
            cvalid3_reg <= cvalid2_reg;
            sync3_reg   <= sync2_reg;
            tout3_reg   <= tout2_reg;
            ovr3_reg    <= ovr2_reg;
            idx3_reg    <= idx2_reg;
            ticks3_reg  <= ticks2_reg;
        end
    end

    assign scale_ctl.en   = adv;
    assign scale_ctl.keep = cvalid1_reg;

    nhcd_scale u_scale
    (
        .clk       (clk),
        .ctl       (scale_ctl),
        .ticks     (ticks1_reg),
        .scale_q16 (scale_q16_reg),
        .offset_us (offset_us_reg),
        .pulse     (pulse)
    );

    assign m_axis_tvalid = v3_reg;
    assign m_axis_tdata  = {pulse, ticks3_reg, idx3_reg, req3_reg};
    assign m_axis_tuser  = {ovr3_reg, tout3_reg, sync3_reg, cvalid3_reg};

endmodule

// ===== bench/nhcd_checker.sv =====
// ----------------------------------------------------------------------------
// nhcd_checker
// Watches the sample, result and register channels of the deframer, follows
// the handshake state of the block on every accepted sample and compares
// each result transaction, field by field, with the oldest channel report
// still due.
// ----------------------------------------------------------------------------
module nhcd_checker
    import nhcd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [SAMPLE_W-1:0]   s_axis_tdata,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [31:0]           m_axis_tdata,
    input  logic [3:0]            m_axis_tuser,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DAT_W-1:0]  cfg_data,
    output int                    fail_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PULSE_HI     = 16383;
    localparam int PULSE_LO     = -4095;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic                       request;
        logic                       chan_valid;
        logic [CH_W-1:0]            chan_index;
        logic [TICKS_W-1:0]         ticks;
        logic signed [PULSE_W-1:0]  pulse_us;
        logic                       sync;
        logic                       timeout;
        logic                       overrun;
    } channel_report_t;

    phase_t                 phase;
    logic [LIMIT_W-1:0]     wait_cnt;
    logic [POS_W-1:0]       nib_pos;
    logic [TICKS_W-1:0]     partial;
    logic [CH_W-1:0]        next_ch;

    logic [LIMIT_W-1:0]     limit;
    logic [SCALE_W-1:0]     scale;
    logic [OFFSET_W-1:0]    offset;

    channel_report_t        reports_due[$];

    function automatic logic signed [PULSE_W-1:0] pulse_from_ticks(
        input logic [TICKS_W-1:0] t
    );
        int unsigned rounded;
        int          us_diff;
        rounded = (32'(t) * 32'(scale) + 32'h8000) >> 16;
        us_diff = int'(rounded) - int'(offset);
        if (us_diff > PULSE_HI)
        begin
            us_diff = PULSE_HI;
        end
        if (us_diff < PULSE_LO)
        begin
            us_diff = PULSE_LO;
        end
        return PULSE_W'(us_diff);
    endfunction

    function automatic channel_report_t decode_sample(input logic [SAMPLE_W-1:0] s);
        channel_report_t    r;
        logic               ready_seen;
        logic [NIB_W-1:0]   nib;
        logic [LIMIT_W:0]   n;
        r = '0;
        ready_seen = !s[BIT_READY_N];
        if ((phase == PH_READY) == ready_seen)
        begin
            wait_cnt = '0;
            if (phase == PH_READY)
            begin
                nib = {!s[BIT_DATA_N], s[5:3]};
                partial = partial | (TICKS_W'(nib) << (4 * nib_pos));
                if (nib_pos >= NIB_LAST)
                begin
                    r.chan_valid = 1'b1;
                    r.ticks = partial;
                    if (next_ch >= CH_W'(MAX_CHANNELS_DEF))
                    begin
                        r.chan_index = CH_W'(MAX_CHANNELS_DEF - 1);
                        r.overrun = 1'b1;
                        next_ch = CH_W'(MAX_CHANNELS_DEF);
                    end
                    else
                    begin
                        r.chan_index = next_ch;
                        next_ch = next_ch + 1'b1;
                    end
                    r.pulse_us = pulse_from_ticks(partial);
                    nib_pos = '0;
                    partial = '0;
                end
                else
                begin
                    nib_pos = nib_pos + 1'b1;
                end
                phase = PH_IDLE;
            end
            else
            begin
                if (s[BIT_SYNC])
                begin
                    r.sync = 1'b1;
                    next_ch = '0;
                    nib_pos = '0;
                    partial = '0;
                end
                phase = PH_READY;
            end
        end
        else
        begin
            n = {1'b0, wait_cnt} + (LIMIT_W+1)'(1);
            if (n >= {1'b0, limit})
            begin
                r.timeout = 1'b1;
                wait_cnt = '0;
                nib_pos = '0;
                partial = '0;
                phase = PH_READY;
            end
            else
            begin
                wait_cnt = n[LIMIT_W-1:0];
            end
        end
        r.request = (phase == PH_READY);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        channel_report_t got;
        channel_report_t want;
        if (!rst_n)
        begin
            phase = PH_READY;
            wait_cnt = '0;
            nib_pos = '0;
            partial = '0;
            next_ch = '0;
            limit = TIMEOUT_RST;
            scale = SCALE_RST;
            offset = OFFSET_RST;
            reports_due.delete();
            pending = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.request    = m_axis_tdata[0];
                got.chan_index = m_axis_tdata[4:1];
                got.ticks      = m_axis_tdata[16:5];
                got.pulse_us   = m_axis_tdata[31:17];
                got.chan_valid = m_axis_tuser[0];
                got.sync       = m_axis_tuser[1];
                got.timeout    = m_axis_tuser[2];
                got.overrun    = m_axis_tuser[3];
                if (reports_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                    begin
                        $display("%0t: result transaction with no sample pending: %h %h",
                                 $realtime, m_axis_tdata, m_axis_tuser);
                    end
                end
                else
                begin
                    want = reports_due.pop_front();
                    if (got.request !== want.request || got.chan_valid !== want.chan_valid
                        || got.chan_index !== want.chan_index || got.ticks !== want.ticks
                        || got.pulse_us !== want.pulse_us || got.sync !== want.sync
                        || got.timeout !== want.timeout || got.overrun !== want.overrun)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                        begin
                            $display("%0t: result mismatch (req vld idx ticks pulse sync tout ovr)",
                                     $realtime);
                            $display("    expected %b %b %0d %0d %0d %b %b %b",
                                     want.request, want.chan_valid, want.chan_index,
                                     want.ticks, $signed(want.pulse_us), want.sync,
                                     want.timeout, want.overrun);
                            $display("    actual   %b %b %0d %0d %0d %b %b %b",
                                     got.request, got.chan_valid, got.chan_index,
                                     got.ticks, $signed(got.pulse_us), got.sync,
                                     got.timeout, got.overrun);
                        end
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_TIMEOUT: limit  = cfg_data[LIMIT_W-1:0];
                    CFG_SCALE:   scale  = cfg_data[SCALE_W-1:0];
                    CFG_OFFSET:  offset = cfg_data[OFFSET_W-1:0];
                    default:     ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                reports_due.push_back(decode_sample(s_axis_tdata));
            end
            pending = reports_due.size();
        end
    end

endmodule

// ===== bench/nibble_handshake_channel_deframer_test.sv =====
// ----------------------------------------------------------------------------
// nibble_handshake_channel_deframer_test
// Drives status samples into the deframer in bursts, runs it through a set
// of timeout, scale and offset settings and lets the checker compare every
// result transaction while the receiver stalls on changing patterns.
// ----------------------------------------------------------------------------
module nibble_handshake_channel_deframer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import nhcd_pkg::*;

    localparam int RUN_LIMIT = 800000;
    localparam int OPENING_N = 20;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_SPARSE,
        SINK_HALF,
        SINK_PATTERN
    } sink_mode_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [SAMPLE_W-1:0]    s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [31:0]            m_axis_tdata;
    logic [3:0]             m_axis_tuser;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DAT_W-1:0]   cfg_data;
    int                     fail_count;
    int                     pending;

    int                     burst_left;
    int                     samples_sent;
    int                     wait_max;
    sink_mode_t             sink_mode;
    int                     sink_left;
    logic [7:0]             sink_pattern;
    logic [SAMPLE_W-1:0]    opening [0:OPENING_N-1];

    nibble_handshake_channel_deframer i_dut (
        .clk,
        .rst_n,
        .s_axis_tvalid,
        .s_axis_tready,
        .s_axis_tdata,
        .m_axis_tvalid,
        .m_axis_tready,
        .m_axis_tdata,
        .m_axis_tuser,
        .cfg_valid,
        .cfg_ready,
        .cfg_index,
        .cfg_data
    );

    nhcd_checker i_checker (
        .clk,
        .rst_n,
        .s_axis_tvalid,
        .s_axis_tready,
        .s_axis_tdata,
        .m_axis_tvalid,
        .m_axis_tready,
        .m_axis_tdata,
        .m_axis_tuser,
        .cfg_valid,
        .cfg_ready,
        .cfg_index,
        .cfg_data,
        .fail_count,
        .pending
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        if (sink_left == 0)
        begin
            sink_mode = sink_mode_t'($urandom_range(0, 3));
            sink_left = $urandom_range(16, 120);
            sink_pattern = 8'($urandom);
        end
        sink_left--;
        case (sink_mode)
            SINK_OPEN:   m_axis_tready <= 1'b1;
            SINK_SPARSE: m_axis_tready <= ($urandom_range(0, 7) != 0);
            SINK_HALF:   m_axis_tready <= ($urandom_range(0, 1) == 1);
            default:
            begin
                m_axis_tready <= sink_pattern[0];
                sink_pattern = {sink_pattern[0], sink_pattern[7:1]};
            end
        endcase
    end

    task automatic push_sample(input logic [SAMPLE_W-1:0] s);
        int gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                gap = 0;
                burst_left = $urandom_range(32, 96);
            end
            else
            begin
                gap = $urandom_range(0, 6);
                burst_left = $urandom_range(1, 16);
            end
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= s;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        burst_left--;
        samples_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DAT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic apply_settings(input int limit, input int scale, input int offset);
        write_reg(CFG_TIMEOUT, CFG_DAT_W'(limit));
        write_reg(CFG_SCALE, CFG_DAT_W'(scale));
        write_reg(CFG_OFFSET, CFG_DAT_W'(offset));
        cfg_valid <= 1'b0;
    endtask

    // Samples that do not satisfy the current wait; look_idle selects bit6.
    task automatic hold_samples(input logic look_idle);
        logic [SAMPLE_W-1:0] b;
        int                  n;
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, wait_max) : 0;
        repeat (n)
        begin
            b = SAMPLE_W'($urandom);
            b[BIT_READY_N] = look_idle;
            push_sample(b);
        end
    endtask

    task automatic send_nibble(input logic [NIB_W-1:0] nib, input logic sync_after);
        logic [SAMPLE_W-1:0] b;
        hold_samples(1'b1);
        b = SAMPLE_W'($urandom);
        b[BIT_READY_N] = 1'b0;
        b[5:3] = nib[2:0];
        b[BIT_DATA_N] = !nib[3];
        push_sample(b);
        hold_samples(1'b0);
        b = SAMPLE_W'($urandom);
        b[BIT_READY_N] = 1'b1;
        b[BIT_SYNC] = sync_after;
        push_sample(b);
    endtask

    task automatic send_frame();
        logic [TICKS_W-1:0] ticks;
        int                 channels;
        channels = $urandom_range(1, 14);
        for (int i = 0; i < channels; i++)
        begin
            case ($urandom_range(0, 9))
                0:       ticks = '0;
                1:       ticks = '1;
                default: ticks = TICKS_W'($urandom);
            endcase
            send_nibble(ticks[3:0], 1'b0);
            send_nibble(ticks[7:4], 1'b0);
            send_nibble(ticks[11:8], i == channels - 1);
        end
    endtask

    task automatic run_random(input int count);
        int target;
        target = samples_sent + count;
        while (samples_sent < target)
        begin
            case ($urandom_range(0, 9))
                7:
                begin
                    repeat ($urandom_range(1, 2))
                    begin
                        send_nibble(NIB_W'($urandom), 1'($urandom));
                    end
                end
                8, 9:
                begin
                    repeat ($urandom_range(1, 6))
                    begin
                        push_sample(SAMPLE_W'($urandom));
                    end
                end
                default: send_frame();
            endcase
        end
    endtask

    initial
    begin : stimulus
        int lim;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_TIMEOUT;
        cfg_data = '0;
        burst_left = 0;
        samples_sent = 0;
        sink_left = 0;
        opening = '{8'h40, 8'h3F, 8'hF7, 8'h3F, 8'h77, 8'h3F, 8'h40,
                    8'h80, 8'hC7, 8'hB8, 8'hC0, 8'h87, 8'h40, 8'h80, 8'hC8,
                    8'h00, 8'h80, 8'hFF, 8'h2A, 8'h48};
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        wait_max = 4;
        foreach (opening[i])
        begin
            push_sample(opening[i]);
        end
        run_random(230);
        wait_drained();

        apply_settings(1, 262143, 0);
        wait_max = 2;
        run_random(250);
        wait_drained();

        apply_settings(0, 0, 4095);
        wait_max = 2;
        run_random(200);
        wait_drained();

        apply_settings(32767, 1, 4095);
        wait_max = 4;
        run_random(250);
        wait_drained();

        apply_settings(24, 56560, 1520);
        wait_max = 30;
        run_random(300);
        wait_drained();

        for (int p = 0; p < 3; p++)
        begin
            lim = $urandom_range(2, 12);
            apply_settings(lim, $urandom_range(1, 262143), $urandom_range(0, 4095));
            wait_max = lim + 2;
            run_random(200);
            wait_drained();
        end

        repeat (16) @(negedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("nibble_handshake_channel_deframer_test: PASS");
        end
        else
        begin
            $display("nibble_handshake_channel_deframer_test: FAIL");
        end
        $finish;
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < RUN_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("nibble_handshake_channel_deframer_test: FAIL");
        $finish;
    end

endmodule
